@@ rtl/core/wae_pkg.sv @@
// Shared constants, types and tables for the windowed average smoother.
package wae_pkg;

	localparam int NCH         = 3;
	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 16;

	localparam int Q88_W      = 16;
	localparam int FRAC_BITS  = 8;
	localparam int KW_W       = 9;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [KW_W-1:0]  KW_RESET  = KW_W'(230);
	localparam logic [KW_W-1:0]  KW_ONE    = KW_W'(256);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(26);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + FILL_W;
	// Reciprocal scale: large enough that the estimated quotient is short by at most one.
	localparam int RK     = SUM_W + 1;
	localparam int RW     = RK + 1;
	localparam int PROD_W = SUM_W + RW;
	localparam int BL_W   = ((SAMPLE_BITS > Q88_W) ? SAMPLE_BITS : Q88_W) + KW_W + 2;
	localparam int DIFF_W = Q88_W + 1;

	localparam logic signed [BL_W-1:0] ROUND_HALF = BL_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [BL_W-1:0] SAT_HI = (BL_W'(1) << (Q88_W - 1)) - BL_W'(1);
	localparam logic signed [BL_W-1:0] SAT_LO = -(BL_W'(1) << (Q88_W - 1));

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_TOL  = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_MUL,
		ST_COMMIT
	} fsm_t;

	typedef struct packed {
		logic push;
		logic div_step;
		logic fix_step;
		logic mul_step;
		logic commit;
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [Q88_W-1:0] value;
		logic                    changed;
	} lane_res_t;

	typedef logic [RW-1:0] recip_tab_t [WINDOW+1];

	// Builds floor(2^RK / f) for every nonzero fill count by long division at elaboration; zero maps to zero.
	function automatic recip_tab_t build_recip();
		recip_tab_t       tab;
		logic [RW-1:0]    q;
		logic [FILL_W:0]  rem;
		tab[0] = '0;
		for (int f = 1; f <= WINDOW; f++) begin
			q   = '0;
			rem = '0;
			for (int b = RK; b >= 0; b--) begin
				rem = {rem[FILL_W-1:0], (b == RK) ? 1'b1 : 1'b0};
				if (rem >= (FILL_W+1)'(f)) begin
					rem  = rem - (FILL_W+1)'(f);
					q[b] = 1'b1;
				end
			end
			tab[f] = q;
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip();

	// Clamps a wide signed value to the signed Q8.8 range.
	function automatic logic signed [Q88_W-1:0] sat_q88(input logic signed [BL_W-1:0] v);
		logic signed [Q88_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[Q88_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[Q88_W-1:0];
		end else begin
			r = v[Q88_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/windowed_average_ema_smoother.sv @@
// Top level of the three-channel windowed average smoother with exponential smoothing.
// A sample request is absorbed in the cycle it is accepted; samples stream one per cycle while no tick runs.
// A tick request walks four steps (divide, quotient fix, blend multiply, commit) in three
// parallel channel lanes; at commit, once the output register is free, the merge stage registers
// the result if any lane changed, and the next request is taken after the sequencer returns to idle.
// Reset (arst_n low) clears sums, fill count, smoothed values; config takes defaults; rings are not cleared.
module windowed_average_ema_smoother import wae_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic signed [15:0]      temp_sample,
	input  logic signed [15:0]      humid_sample,
	input  logic signed [15:0]      air_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [Q88_W-1:0] temp_value,
	output logic signed [Q88_W-1:0] humid_value,
	output logic signed [Q88_W-1:0] air_value,
	output logic [NCH-1:0]          changed_mask,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
	logic [KW_W-1:0]  keep_weight_q;
	logic [TOL_W-1:0] change_tol_q;
	logic [KW_W-1:0]  kw_eff;

	// Window bookkeeping shared by all lanes.
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;

	fsm_t       state_q;
	fsm_t       state_d;
	lane_ctrl_t ctrl;
	logic       in_acc;
	logic       out_free;

	logic signed [SAMPLE_BITS-1:0] lane_smp [NCH];
	lane_res_t                     lane_res [NCH];

	assign in_acc = in_valid && !in_stall;

	// Weights above one full unit behave as a full unit: the old value is simply kept.
	assign kw_eff = (keep_weight_q > KW_ONE) ? KW_ONE : keep_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_weight_q <= KW_RESET;
			change_tol_q  <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEEP_WEIGHT: keep_weight_q <= cfg_data[KW_W-1:0];
				CFG_CHANGE_TOL:  change_tol_q  <= cfg_data[TOL_W-1:0];
			endcase
		end
	end

	// The sequencer: samples are handled in the idle state itself, a tick steps through
	// the lane pipeline and waits at commit until the output register can take the result.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == CMD_TICK)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV:    state_d = ST_FIX;
			ST_FIX:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		ctrl          = '0;
		ctrl.push     = (state_q == ST_IDLE) && in_valid && (cmd == CMD_SAMPLE);
		ctrl.div_step = (state_q == ST_DIV);
		ctrl.fix_step = (state_q == ST_FIX);
		ctrl.mul_step = (state_q == ST_MUL);
		ctrl.commit   = (state_q == ST_COMMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.push) begin
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
				if (fill_q != FILL_W'(WINDOW)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// Samples are taken as two's complement of the lane sample width.
	assign lane_smp[0] = SAMPLE_BITS'(temp_sample);
	assign lane_smp[1] = SAMPLE_BITS'(humid_sample);
	assign lane_smp[2] = SAMPLE_BITS'(air_sample);

	for (genvar g = 0; g < NCH; g++) begin : gen_lane
		wae_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.sample      (lane_smp[g]),
			.slot        (slot_q),
			.fill        (fill_q),
			.keep_weight (kw_eff),
			.change_tol  (change_tol_q),
			.res         (lane_res[g])
		);
	end

	wae_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (ctrl.commit),
		.res          (lane_res),
		.out_stall    (out_stall),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.temp_value   (temp_value),
		.humid_value  (humid_value),
		.air_value    (air_value),
		.changed_mask (changed_mask)
	);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count beyond the window");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SLOT_W+1)'(WINDOW))
		else $error("write slot outside the ring");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_TICK)) |=> (state_q == ST_DIV))
		else $error("accepted tick did not start the lane pipeline");

	a_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> ($past(state_q) == ST_MUL || $past(state_q) == ST_COMMIT))
		else $error("commit without the multiply step before it");

endmodule

@@ rtl/core/wae_lane.sv @@
// One channel lane: sample ring, running sum, average by reciprocal and smoothing blend.
module wae_lane import wae_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [SLOT_W-1:0]             slot,
	input  logic [FILL_W-1:0]             fill,
	input  logic [KW_W-1:0]               keep_weight,
	input  logic [TOL_W-1:0]              change_tol,
	output lane_res_t                     res
);

	logic signed [SAMPLE_BITS-1:0] ring_q [WINDOW];
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [Q88_W-1:0]       smooth_q;
	logic                          valid_q;

	logic [SUM_W-1:0]              mag_s1;
	logic [SUM_W-1:0]              q_est_s1;
	logic                          neg_s1;
	logic signed [SAMPLE_BITS-1:0] avg_s2;
	logic signed [SAMPLE_BITS-1:0] avg_s3;
	logic signed [BL_W-1:0]        prod_old_s3;
	logic signed [BL_W-1:0]        prod_avg_s3;
	logic                          skip_s3;

	logic signed [SUM_W-1:0]       sum_drop;
	logic signed [SUM_W-1:0]       sum_next;
	logic                          sum_neg;
	logic [SUM_W-1:0]              sum_mag;
	logic [PROD_W-1:0]             recip_prod;
	logic [SUM_W-1:0]              qf;
	logic [SUM_W-1:0]              rem;
	logic [SUM_W-1:0]              q_fix;
	logic signed [BL_W-1:0]        kw_ext;
	logic signed [BL_W-1:0]        aw_ext;
	logic signed [BL_W-1:0]        old_ext;
	logic signed [BL_W-1:0]        avg_ext;
	logic signed [BL_W-1:0]        blend_t;
	logic signed [BL_W-1:0]        blend_sh;
	logic signed [Q88_W-1:0]       nv;
	logic signed [Q88_W-1:0]       first_v;
	logic signed [DIFF_W-1:0]      diff;
	logic [DIFF_W-1:0]             abs_diff;
	logic                          moved;

	// Window update: once full, the oldest sample leaves the sum.
	assign sum_drop = (fill == FILL_W'(WINDOW)) ? SUM_W'(ring_q[slot]) : '0;
	assign sum_next = sum_q - sum_drop + SUM_W'(sample);

	assign sum_neg    = sum_q[SUM_W-1];
	assign sum_mag    = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign recip_prod = PROD_W'(sum_mag) * PROD_W'(RECIP_TAB[fill]);

	// The reciprocal estimate can be one short; one compare fixes it.
	assign qf    = q_est_s1 * SUM_W'(fill);
	assign rem   = mag_s1 - qf;
	assign q_fix = q_est_s1 + SUM_W'(rem >= SUM_W'(fill));

	assign kw_ext  = BL_W'($signed({1'b0, keep_weight}));
	assign aw_ext  = BL_W'($signed({1'b0, KW_ONE - keep_weight}));
	assign old_ext = BL_W'(smooth_q);
	assign avg_ext = BL_W'(avg_s2);

	assign blend_t  = prod_old_s3 + prod_avg_s3 + ROUND_HALF;
	assign blend_sh = blend_t >>> FRAC_BITS;
	assign nv       = sat_q88(blend_sh);
	assign first_v  = sat_q88(BL_W'(avg_s3));
	assign diff     = DIFF_W'(nv) - DIFF_W'(smooth_q);
	assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign moved    = abs_diff > DIFF_W'(change_tol);

	always_comb begin
		res.changed = !skip_s3 && (!valid_q || moved);
		if (skip_s3) begin
			res.value = smooth_q;
		end else if (!valid_q) begin
			res.value = first_v;
		end else if (moved) begin
			res.value = nv;
		end else begin
			res.value = smooth_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			ring_q[slot] <= sample;
		end
		if (ctrl.div_step) begin
			mag_s1   <= sum_mag;
			neg_s1   <= sum_neg;
			q_est_s1 <= recip_prod[RK+SUM_W-1:RK];
		end
		if (ctrl.fix_step) begin
			avg_s2 <= neg_s1 ? SAMPLE_BITS'(-q_fix) : SAMPLE_BITS'(q_fix);
		end
		if (ctrl.mul_step) begin
			prod_old_s3 <= kw_ext * old_ext;
			prod_avg_s3 <= aw_ext * avg_ext;
			avg_s3      <= avg_s2;
			skip_s3     <= (fill == '0) || (avg_s2 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			smooth_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (ctrl.push) begin
				sum_q <= sum_next;
			end
			if (ctrl.commit) begin
				smooth_q <= res.value;
				if (!skip_s3) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/core/wae_merge.sv @@
// Merging stage: gathers the lane outcomes into one registered result when at least one lane changed.
module wae_merge import wae_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    commit,
	input  lane_res_t               res [NCH],
	input  logic                    out_stall,
	output logic                    out_free,
	output logic                    out_valid,
	output logic signed [Q88_W-1:0] temp_value,
	output logic signed [Q88_W-1:0] humid_value,
	output logic signed [Q88_W-1:0] air_value,
	output logic [NCH-1:0]          changed_mask
);

	logic                    out_valid_q;
	logic signed [Q88_W-1:0] temp_q;
	logic signed [Q88_W-1:0] humid_q;
	logic signed [Q88_W-1:0] air_q;
	logic [NCH-1:0]          mask_q;
	logic [NCH-1:0]          mask;
	logic                    load;

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			mask[i] = res[i].changed;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load     = commit && (mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			temp_q  <= res[0].value;
			humid_q <= res[1].value;
			air_q   <= res[2].value;
			mask_q  <= mask;
		end
	end

	assign out_valid    = out_valid_q;
	assign temp_value   = temp_q;
	assign humid_value  = humid_q;
	assign air_value    = air_q;
	assign changed_mask = mask_q;

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mask_q != '0))
		else $error("result shown with an empty changed mask");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && out_valid_q) |-> !out_stall)
		else $error("tick committed over a result that is still waiting");

endmodule

@@ sim/windowed_average_ema_smoother_tb.sv @@
// Self-checking testbench for the three-channel windowed average smoother.
module windowed_average_ema_smoother_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wae_pkg::*;

	// Settling time after draining, long enough to be sure that a tick which produced no
	// reading has left the block.
	localparam int SETTLE_CYCLES = 10;
	// Longest receiver hold-off, used once to fill the block and push back on the sender.
	localparam int HOLD_CYCLES   = 300;
	// Cycles without any accepted request or reading before the run is declared hung.
	localparam int IDLE_LIMIT    = 2000;
	localparam int PHASE_ITEMS   = 205;
	localparam int NUM_PHASES    = 6;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic                    cmd;
		logic signed [Q88_W-1:0] temp;
		logic signed [Q88_W-1:0] humid;
		logic signed [Q88_W-1:0] air;
	} request_t;

	typedef struct packed {
		logic signed [Q88_W-1:0] temp;
		logic signed [Q88_W-1:0] humid;
		logic signed [Q88_W-1:0] air;
		logic [NCH-1:0]          mask;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    cmd = CMD_SAMPLE;
	logic signed [15:0]      temp_sample = '0;
	logic signed [15:0]      humid_sample = '0;
	logic signed [15:0]      air_sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [Q88_W-1:0] temp_value;
	logic signed [Q88_W-1:0] humid_value;
	logic signed [Q88_W-1:0] air_value;
	logic [NCH-1:0]          changed_mask;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_KEEP_WEIGHT;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	windowed_average_ema_smoother dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.temp_sample  (temp_sample),
		.humid_sample (humid_sample),
		.air_sample   (air_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temp_value   (temp_value),
		.humid_value  (humid_value),
		.air_value    (air_value),
		.changed_mask (changed_mask),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Requests waiting to be offered, and readings the smoother model says must come out.
	request_t request_queue [$];
	reading_t predicted_readings [$];
	int       queued_total = 0;

	// Mirror of the block's state: one sample ring per channel with its running sum,
	// the shared write slot and fill count, and the smoothed value of each channel.
	logic signed [15:0]      sample_ring [NCH][WINDOW];
	longint                  window_sum [NCH];
	int                      ring_slot = 0;
	int                      ring_fill = 0;
	logic signed [Q88_W-1:0] smoothed [NCH];
	logic [NCH-1:0]          has_value = '0;
	logic [KW_W-1:0]         keep_weight = KW_RESET;
	logic [TOL_W-1:0]        change_tol = TOL_RESET;

	// Handshake bookkeeping shared between the driver, the receiver and the checker.
	logic in_fire = 1'b0;
	logic hold_request = 1'b0;
	int   fail_count = 0;
	int   idle_cycles = 0;

	initial begin
		for (int ch = 0; ch < NCH; ch++) begin
			window_sum[ch] = 0;
			smoothed[ch] = '0;
		end
	end

	function automatic longint clamp_q88(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Advances the smoother model by one accepted request. A tick on which some
	// channel moved queues the reading the block has to produce.
	function automatic void absorb_request(request_t r);
		logic signed [15:0] s [NCH];
		logic [NCH-1:0]     moved;
		longint             avg;
		longint             blended;
		longint             delta;
		longint             kw;
		s = '{r.temp, r.humid, r.air};
		moved = '0;
		if (r.cmd == CMD_SAMPLE) begin
			// Once the window is full the oldest sample drops out of the sum.
			for (int ch = 0; ch < NCH; ch++) begin
				if (ring_fill >= WINDOW) window_sum[ch] -= sample_ring[ch][ring_slot];
				sample_ring[ch][ring_slot] = s[ch];
				window_sum[ch] += s[ch];
			end
			ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
			if (ring_fill < WINDOW) ring_fill++;
		end else begin
			// Weights above one are treated as exactly one.
			kw = (keep_weight > KW_ONE) ? 256 : keep_weight;
			for (int ch = 0; ch < NCH; ch++) begin
				// An empty window or an average of zero leaves the channel alone.
				if (ring_fill == 0) continue;
				avg = window_sum[ch] / ring_fill;
				if (avg == 0) continue;
				if (!has_value[ch]) begin
					smoothed[ch] = Q88_W'(clamp_q88(avg));
					has_value[ch] = 1'b1;
					moved[ch] = 1'b1;
					continue;
				end
				// Rounded blend, floor division by 256 through an arithmetic shift.
				blended = clamp_q88((kw * smoothed[ch] + (256 - kw) * avg + 128) >>> FRAC_BITS);
				delta = blended - smoothed[ch];
				if (delta < 0) delta = -delta;
				if (delta > longint'(change_tol)) begin
					smoothed[ch] = Q88_W'(blended);
					moved[ch] = 1'b1;
				end
			end
			// Channels that never got a value report zero, which is their reset value.
			if (moved != '0)
				predicted_readings.push_back('{smoothed[0], smoothed[1], smoothed[2], moved});
		end
	endfunction

	// No gap half the time, otherwise mostly short ones and a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 17) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_request(logic c, logic signed [15:0] t,
			logic signed [15:0] h, logic signed [15:0] a);
		request_queue.push_back('{c, t, h, a});
		queued_total++;
	endfunction

	// Samples mostly cluster around a level so that the smoothed value settles and the
	// tolerance test matters; the rest are extremes, zeros and arbitrary bit patterns.
	function automatic logic signed [15:0] sample_near(int level);
		int noise;
		noise = $urandom_range(0, 600);
		case ($urandom_range(0, 15))
			0, 1:    return 16'($urandom);
			2:       return 16'sh7FFF;
			3:       return 16'sh8000;
			4:       return '0;
			default: return 16'(level + noise - 300);
		endcase
	endfunction

	// One burst: a run of samples around fresh per-channel levels, then one or two ticks.
	// A burst of no samples gives back-to-back ticks that only test the tolerance.
	function automatic void queue_burst();
		int levels [NCH];
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 25) : $urandom_range(0, 6);
		for (int ch = 0; ch < NCH; ch++) begin
			if ($urandom_range(0, 9) < 7)
				levels[ch] = $urandom_range(0, 4000) - 2000;
			else
				levels[ch] = int'(16'($urandom)) - 32768;
		end
		for (int i = 0; i < n; i++)
			queue_request(CMD_SAMPLE, sample_near(levels[0]), sample_near(levels[1]),
				sample_near(levels[2]));
		// Sample fields on a tick are ignored, so they carry random junk.
		queue_request(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			queue_request(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	// Registers are only written while the block is idle, so the model can take the
	// new value at once.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_KEEP_WEIGHT)
			keep_weight = data[KW_W-1:0];
		else
			change_tol = data[TOL_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every request has been taken and every predicted reading has come
	// out, then gives a tick that produced nothing time to finish.
	task automatic wait_drained();
		while (request_queue.size() != 0 || in_valid || predicted_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sender. A request stays on the port until taken; after that a gap is drawn. The
	// sender alternates between calm stretches with no gaps and bursty stretches.
	int   in_gap = 0;
	int   in_mode_left = 0;
	logic in_calm = 1'b0;

	always @(negedge clk) begin : drive_requests
		request_t item;
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0 || request_queue.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap > 0) in_gap--;
			end else begin
				item = request_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= item.cmd;
				temp_sample <= item.temp;
				humid_sample <= item.humid;
				air_sample <= item.air;
				if (in_mode_left == 0) begin
					in_calm = !in_calm;
					in_mode_left = $urandom_range(20, 150);
				end else begin
					in_mode_left--;
				end
				in_gap = in_calm ? 0 : pick_gap();
			end
		end
	end

	// Receiver. Stall runs of random length with the stall released between runs,
	// plus one long hold-off on request that lets the block back up into its input.
	int   stall_left = 0;
	int   hold_left = 0;
	int   out_mode_left = 0;
	logic out_calm = 1'b0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			if (out_mode_left == 0) begin
				out_calm = !out_calm;
				out_mode_left = $urandom_range(20, 150);
			end else begin
				out_mode_left--;
			end
			stall_left = out_calm ? 0 : pick_gap();
			out_stall <= 1'b0;
		end
	end

	// Checker. Every accepted request goes through the model; every accepted reading is
	// compared with the oldest prediction. The watchdog sits at the end of the block.
	always @(posedge clk) begin : check_readings
		reading_t got;
		reading_t want;
		logic     out_fire;
		in_fire = in_valid && !in_stall;
		out_fire = out_valid && !out_stall;
		if (arst_n && out_fire) begin
			got = '{temp_value, humid_value, air_value, changed_mask};
			if (predicted_readings.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: reading with none predicted: t=%0d h=%0d a=%0d mask=%b",
						$realtime, got.temp, got.humid, got.air, got.mask);
			end else begin
				want = predicted_readings.pop_front();
				if (got.temp !== want.temp || got.humid !== want.humid ||
						got.air !== want.air || got.mask !== want.mask) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: reading mismatch: expected t=%0d h=%0d a=%0d mask=%b, got t=%0d h=%0d a=%0d mask=%b",
							$realtime, want.temp, want.humid, want.air, want.mask,
							got.temp, got.humid, got.air, got.mask);
				end
			end
		end
		if (arst_n && in_fire)
			absorb_request('{cmd, temp_sample, humid_sample, air_sample});
		if (in_fire || out_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("windowed_average_ema_smoother regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int phase_end;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, at the reset weights. A tick on an empty window and a tick on an
		// all-zero window must both stay silent.
		queue_request(CMD_TICK, '0, '0, '0);
		queue_request(CMD_SAMPLE, '0, '0, '0);
		queue_request(CMD_TICK, '0, '0, '0);
		// Only temperature gets a nonzero average: its first value is taken directly and
		// the other two channels report zero.
		queue_request(CMD_SAMPLE, 16'sd256, '0, '0);
		queue_request(CMD_TICK, '0, '0, '0);
		// Extremes: temperature blends, humidity and air quality take first values.
		queue_request(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sd100);
		queue_request(CMD_TICK, '0, '0, '0);
		// Eleven alternating extremes run the window past full so the oldest entries get
		// overwritten; air quality alternates +1/-1 and averages to zero.
		for (int i = 0; i < 11; i++)
			queue_request(CMD_SAMPLE, i[0] ? 16'sh7FFF : 16'sh8000,
				i[0] ? 16'sh8000 : 16'sh7FFF, i[0] ? 16'sh0001 : 16'shFFFF);
		queue_request(CMD_TICK, '0, '0, '0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase != 0) wait_drained();
			case (phase)
				1: begin
					// Average taken as is and every change counts; the long hold-off
					// happens here because almost every tick produces a reading.
					write_reg(CFG_KEEP_WEIGHT, 16'd0);
					write_reg(CFG_CHANGE_TOL, 16'd0);
					hold_request = 1'b1;
				end
				2: begin
					write_reg(CFG_KEEP_WEIGHT, CFG_DATA_W'(KW_ONE));
					write_reg(CFG_CHANGE_TOL, 16'hFFFF);
				end
				3: begin
					// Weight beyond one with junk above the register width.
					write_reg(CFG_KEEP_WEIGHT, 16'hFFFF);
					write_reg(CFG_CHANGE_TOL, 16'd1);
				end
				4: begin
					write_reg(CFG_KEEP_WEIGHT, 16'($urandom_range(0, 256)));
					write_reg(CFG_CHANGE_TOL, 16'($urandom_range(0, 200)));
				end
				5: begin
					write_reg(CFG_KEEP_WEIGHT, 16'($urandom));
					write_reg(CFG_CHANGE_TOL, 16'($urandom_range(0, 511)));
				end
				default: ;
			endcase
			phase_end = queued_total + PHASE_ITEMS;
			while (queued_total < phase_end) queue_burst();
		end

		wait_drained();
		if (fail_count == 0 && predicted_readings.size() == 0) begin
			$display("windowed_average_ema_smoother regression: pass");
		end else begin
			$display("windowed_average_ema_smoother regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/wae_pkg.sv
rtl/core/wae_lane.sv
rtl/core/wae_merge.sv
rtl/core/windowed_average_ema_smoother.sv
sim/windowed_average_ema_smoother_tb.sv
